>>> sv/msce_pkg.sv
// Package of shared constants for the modular surd coefficient engine.
package msce_pkg;

  // Configuration register indexes.
  typedef enum logic {
    REG_MODULUS  = 1'b0,
    REG_RADICAND = 1'b1
  } reg_index_t;

  // Modulus value after reset.
  localparam logic [63:0] MODULUS_RESET = 64'd576460752303423433;

  // Width of the configuration data bus and of its address.
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 4;

endpackage

>>> sv/msce_if.sv
// Request and result channel interfaces of the coefficient engine.
interface msce_in_if #(parameter int unsigned W = 59);
  logic         valid;
  logic         ready;
  logic [W-1:0] first_num_rational;
  logic [W-1:0] first_num_surd;
  logic [W-1:0] first_den_rational;
  logic [W-1:0] first_den_surd;
  logic [W-1:0] second_num_rational;
  logic [W-1:0] second_num_surd;
  logic [W-1:0] second_den_rational;
  logic [W-1:0] second_den_surd;
  logic [W-1:0] weight_num_num;
  logic [W-1:0] weight_den_num;
  logic [W-1:0] weight_num_den;
  logic [W-1:0] weight_den_den;

  modport source (
    output valid, first_num_rational, first_num_surd, first_den_rational,
           first_den_surd, second_num_rational, second_num_surd,
           second_den_rational, second_den_surd, weight_num_num,
           weight_den_num, weight_num_den, weight_den_den,
    input  ready
  );
  modport sink (
    input  valid, first_num_rational, first_num_surd, first_den_rational,
           first_den_surd, second_num_rational, second_num_surd,
           second_den_rational, second_den_surd, weight_num_num,
           weight_den_num, weight_num_den, weight_den_den,
    output ready
  );
endinterface

interface msce_out_if #(parameter int unsigned W = 59);
  logic         valid;
  logic         ready;
  logic [W-1:0] coef_rational;
  logic [W-1:0] coef_surd;

  modport source (output valid, coef_rational, coef_surd, input ready);
  modport sink (input valid, coef_rational, coef_surd, output ready);
endinterface

>>> sv/msce_cell.sv
// One bit step of an interleaved modular multiplication.
module msce_cell #(
  parameter int unsigned W = 59
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] modulus,
  input  logic [W-1:0] a_in,
  input  logic [W-1:0] b_in,
  input  logic [W-1:0] acc_in,
  output logic [W-1:0] a_out,
  output logic [W-1:0] b_out,
  output logic [W-1:0] acc_out
);

  logic [W:0]   dbl;
  logic [W:0]   dbl_red;
  logic [W:0]   sum;
  logic [W:0]   sum_red;
  logic [W-1:0] acc_next;

  // Double the accumulator, then add the multiplicand when the top bit is set.
  always_comb begin
    dbl     = {acc_in, 1'b0};
    dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
    sum     = {1'b0, dbl_red[W-1:0]} + {1'b0, a_in};
    sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
    acc_next = b_in[W-1] ? sum_red[W-1:0] : dbl_red[W-1:0];
  end

  // Hand the partial result and the shifted multiplier to the next cell.
  always_ff @(posedge clk) begin
    if (en) begin
      a_out   <= a_in;
      b_out   <= {b_in[W-2:0], 1'b0};
      acc_out <= acc_next;
    end
  end

endmodule

>>> sv/msce_mulrow.sv
// Row of bit cells forming a pipelined modular multiplier.
module msce_mulrow #(
  parameter int unsigned W = 59
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] modulus,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] prod
);

  logic [W-1:0] a_line   [W+1];
  logic [W-1:0] b_line   [W+1];
  logic [W-1:0] acc_line [W+1];

  assign a_line[0]   = a;
  assign b_line[0]   = b;
  assign acc_line[0] = '0;

  // One cell for each multiplier bit, most significant first.
  for (genvar i = 0; i < W; i++) begin : g_cell
    msce_cell #(.W(W)) u_cell (
      .clk     (clk),
      .en      (en),
      .modulus (modulus),
      .a_in    (a_line[i]),
      .b_in    (b_line[i]),
      .acc_in  (acc_line[i]),
      .a_out   (a_line[i+1]),
      .b_out   (b_line[i+1]),
      .acc_out (acc_line[i+1])
    );
  end

  assign prod = acc_line[W];

endmodule

>>> sv/msce_delay.sv
// Shift line that keeps side data aligned with the multiplier rows.
module msce_delay #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [DEPTH];

  // Advance every tap together; reset clears the line so valid flags start low.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) line[i] <= '0;
    end else if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) line[i] <= line[i-1];
    end
  end

  assign q = line[DEPTH-1];

endmodule

>>> sv/modular_surd_coefficient_engine.sv
// A request passes the reduction, cross-product, weighting, adder and radicand stages, then the result register.
// Throughput: one request per cycle; the pipeline moves whenever the result
// register is empty or being taken, so a stall on the result side holds it.
// Each multiplication runs through a row of RESIDUE_WIDTH bit cells.
// Reset (synchronous, rst high) empties the pipeline and sets the modulus to
// 576460752303423433 and the radicand to zero.
module modular_surd_coefficient_engine #(
  parameter int unsigned RESIDUE_WIDTH = 59
) (
  input  logic                              clk,
  input  logic                              rst,
  msce_in_if.sink                           src,
  msce_out_if.source                        dst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [msce_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [msce_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [msce_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int unsigned W = RESIDUE_WIDTH;
  localparam int unsigned VDEPTH = 4 * W + 2;

  logic [W-1:0] modulus;
  logic [W-1:0] radicand;
  logic         adv;
  logic         pipe_valid;

  function automatic logic [W-1:0] add_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sub_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
    return (x >= y) ? x - y : x + (m - y);
  endfunction

  // Configuration registers.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= msce_pkg::MODULUS_RESET[W-1:0];
      radicand <= '0;
    end else if (psel && penable && pwrite) begin
      case (msce_pkg::reg_index_t'(paddr[3]))
        msce_pkg::REG_MODULUS:  modulus  <= pwdata[W-1:0];
        msce_pkg::REG_RADICAND: radicand <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (msce_pkg::reg_index_t'(paddr[3]))
      msce_pkg::REG_MODULUS:  prdata = {{(msce_pkg::CFG_DATA_W-W){1'b0}}, modulus};
      msce_pkg::REG_RADICAND: prdata = {{(msce_pkg::CFG_DATA_W-W){1'b0}}, radicand};
      default:                prdata = '0;
    endcase
  end

  // The whole pipeline advances while the result register can take a value.
  assign adv       = !dst.valid || dst.ready;
  assign src.ready = adv;

  msce_delay #(.WIDTH(1), .DEPTH(VDEPTH)) u_vld (
    .clk(clk), .rst(rst), .en(adv), .d(src.valid), .q(pipe_valid)
  );

  // Stage one: reduce the first fraction's parts, as multiplication by one.
  logic [W-1:0] raw1 [4];
  logic [W-1:0] red1 [4];
  assign raw1[0] = src.first_num_rational;
  assign raw1[1] = src.first_num_surd;
  assign raw1[2] = src.first_den_rational;
  assign raw1[3] = src.first_den_surd;
  for (genvar i = 0; i < 4; i++) begin : g_red
    msce_mulrow #(.W(W)) u_row (
      .clk(clk), .en(adv), .modulus(modulus),
      .a({{(W-1){1'b0}}, 1'b1}), .b(raw1[i]), .prod(red1[i])
    );
  end

  logic [8*W-1:0] side1_d;
  logic [8*W-1:0] side1_q;
  assign side1_d = {src.second_num_rational, src.second_num_surd,
                    src.second_den_rational, src.second_den_surd,
                    src.weight_num_num, src.weight_den_num,
                    src.weight_num_den, src.weight_den_den};
  msce_delay #(.WIDTH(8*W), .DEPTH(W)) u_side1 (
    .clk(clk), .rst(1'b0), .en(adv), .d(side1_d), .q(side1_q)
  );

  logic [W-1:0] sP, sQ, sR, sT;
  logic [4*W-1:0] wts1;
  assign {sP, sQ, sR, sT, wts1} = side1_q;

  // Stage two: the sixteen cross products of the two fractions.
  logic [W-1:0] a2 [16];
  logic [W-1:0] b2 [16];
  logic [W-1:0] x2 [16];
  always_comb begin
    a2[0]  = red1[0]; b2[0]  = sP;
    a2[1]  = red1[0]; b2[1]  = sR;
    a2[2]  = red1[2]; b2[2]  = sP;
    a2[3]  = red1[2]; b2[3]  = sR;
    a2[4]  = red1[1]; b2[4]  = sQ;
    a2[5]  = red1[1]; b2[5]  = sT;
    a2[6]  = red1[3]; b2[6]  = sQ;
    a2[7]  = red1[3]; b2[7]  = sT;
    a2[8]  = red1[0]; b2[8]  = sQ;
    a2[9]  = red1[1]; b2[9]  = sP;
    a2[10] = red1[0]; b2[10] = sT;
    a2[11] = red1[1]; b2[11] = sR;
    a2[12] = red1[3]; b2[12] = sP;
    a2[13] = red1[2]; b2[13] = sQ;
    a2[14] = red1[2]; b2[14] = sT;
    a2[15] = red1[3]; b2[15] = sR;
  end
  for (genvar i = 0; i < 16; i++) begin : g_cross
    msce_mulrow #(.W(W)) u_row (
      .clk(clk), .en(adv), .modulus(modulus), .a(a2[i]), .b(b2[i]), .prod(x2[i])
    );
  end

  logic [4*W-1:0] wts2;
  msce_delay #(.WIDTH(4*W), .DEPTH(W)) u_side2 (
    .clk(clk), .rst(1'b0), .en(adv), .d(wts1), .q(wts2)
  );
  logic [W-1:0] wnn, wdn, wnd, wdd;
  assign {wnn, wdn, wnd, wdd} = wts2;

  // Stage three: weight every term; the surd coefficient pairs are summed first.
  logic [W-1:0] a3 [12];
  logic [W-1:0] b3 [12];
  logic [W-1:0] x3 [12];
  always_comb begin
    a3[0]  = x2[0];  b3[0]  = wnn;
    a3[1]  = x2[1];  b3[1]  = wnd;
    a3[2]  = x2[2];  b3[2]  = wdn;
    a3[3]  = x2[3];  b3[3]  = wdd;
    a3[4]  = x2[4];  b3[4]  = wnn;
    a3[5]  = x2[5];  b3[5]  = wnd;
    a3[6]  = x2[6];  b3[6]  = wdn;
    a3[7]  = x2[7];  b3[7]  = wdd;
    a3[8]  = add_m(x2[8], x2[9], modulus);   b3[8]  = wnn;
    a3[9]  = add_m(x2[10], x2[11], modulus); b3[9]  = wnd;
    a3[10] = add_m(x2[12], x2[13], modulus); b3[10] = wdn;
    a3[11] = add_m(x2[14], x2[15], modulus); b3[11] = wdd;
  end
  for (genvar i = 0; i < 12; i++) begin : g_wt
    msce_mulrow #(.W(W)) u_row (
      .clk(clk), .en(adv), .modulus(modulus), .a(a3[i]), .b(b3[i]), .prod(x3[i])
    );
  end

  // Two adder stages fold the signed terms together.
  logic [W-1:0] ra1, ra2, su1, su2, rb1, rb2;
  logic [W-1:0] ra, su, rb;
  always_ff @(posedge clk) begin
    if (adv) begin
      ra1 <= sub_m(x3[0], x3[1], modulus);
      ra2 <= sub_m(x3[3], x3[2], modulus);
      su1 <= sub_m(x3[4], x3[5], modulus);
      su2 <= sub_m(x3[7], x3[6], modulus);
      rb1 <= sub_m(x3[8], x3[9], modulus);
      rb2 <= sub_m(x3[11], x3[10], modulus);
      ra  <= add_m(ra1, ra2, modulus);
      su  <= add_m(su1, su2, modulus);
      rb  <= add_m(rb1, rb2, modulus);
    end
  end

  // Stage four: scale the surd sum by the radicand.
  logic [W-1:0] x4;
  logic [2*W-1:0] side4;
  msce_mulrow #(.W(W)) u_rad (
    .clk(clk), .en(adv), .modulus(modulus), .a(su), .b(radicand), .prod(x4)
  );
  msce_delay #(.WIDTH(2*W), .DEPTH(W)) u_side4 (
    .clk(clk), .rst(1'b0), .en(adv), .d({ra, rb}), .q(side4)
  );

  // Result register; a modulus below two gives zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      dst.valid <= 1'b0;
    end else if (adv) begin
      dst.valid <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (modulus < W'(2)) begin
        dst.coef_rational <= '0;
        dst.coef_surd     <= '0;
      end else begin
        dst.coef_rational <= add_m(side4[2*W-1:W], x4, modulus);
        dst.coef_surd     <= side4[W-1:0];
      end
    end
  end

endmodule
